@@ sv/wbps_pkg.sv @@
// ----------------------------------------------------------------------------
// wbps_pkg: shared types and constants of the wildcard byte pattern scanner
// widths of the stream fields, register indexes and the per-cell compare setup
// ----------------------------------------------------------------------------
package wbps_pkg;

  localparam int BYTE_W           = 8;
  localparam int ADDR_W           = 64;
  localparam int CFG_W            = 64;
  localparam int CFG_IDX_W        = 3;
  localparam int MASK_W           = 16;
  localparam int LEN_W            = 5;
  localparam int STORED_POSITIONS = 16;
  localparam int POS_W            = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LOW  = 3'd0,
    REG_PAT_HIGH = 3'd1,
    REG_WILDCARD = 3'd2,
    REG_LENGTH   = 3'd3,
    REG_BASE     = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic              used;
    logic              wild;
    logic [BYTE_W-1:0] pat_byte;
  } cell_cfg_t;

endpackage

@@ sv/wbps_cell.sv @@
// ----------------------------------------------------------------------------
// wbps_cell: one position of the shift window
// holds one byte, passes it on to the older neighbor on each shift and
// compares the byte it takes in against its pattern position
// ----------------------------------------------------------------------------
module wbps_cell (
  input  logic                      clk,
  input  logic                      shift_en,
  input  logic [wbps_pkg::BYTE_W-1:0] din,
  input  wbps_pkg::cell_cfg_t       cfg,
  output logic [wbps_pkg::BYTE_W-1:0] dout,
  output logic                      hit
);
  import wbps_pkg::*;

  logic [BYTE_W-1:0] byte_r;
  logic [BYTE_W-1:0] byte_nxt;

  assign byte_nxt = shift_en ? din : byte_r;

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign dout = byte_r;

  // compare the byte entering this cell, i.e. the window after the shift
  assign hit = !cfg.used || cfg.wild || (din == cfg.pat_byte);

endmodule

@@ sv/wildcard_byte_pattern_scanner.sv @@
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner: leftmost masked pattern search on a byte stream
// result: a result item is registered and shown in the cycle after its byte is taken
// throughput: one byte per cycle, set by the shift chain and its parallel compare
// a result not yet taken holds off input; one taken in that cycle lets a byte in
// reset: synchronous active low; clears config to defaults and the scan state
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner #(
  parameter int MAX_PATTERN = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [wbps_pkg::BYTE_W-1:0]    in_tdata,   // [7:0] data_byte
  input  logic                           in_tlast,   // region_end
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [wbps_pkg::ADDR_W-1:0]    out_tdata,  // [63:0] match_address
  output logic [0:0]                     out_tuser,  // [0] found
  input  logic                           cfg_we,
  input  logic [wbps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wbps_pkg::CFG_W-1:0]     cfg_wdata
);
  import wbps_pkg::*;

  localparam int NUM_CELLS = (MAX_PATTERN < STORED_POSITIONS) ? MAX_PATTERN
                                                              : STORED_POSITIONS;
  localparam int FILL_W    = $clog2(NUM_CELLS + 1);
  localparam logic [LEN_W-1:0]  LEN_CAP  = LEN_W'(NUM_CELLS);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(NUM_CELLS);

  // configuration registers
  logic [CFG_W-1:0]  pat_low_r;
  logic [CFG_W-1:0]  pat_high_r;
  logic [MASK_W-1:0] wild_mask_r;
  logic [LEN_W-1:0]  length_r;
  logic [ADDR_W-1:0] base_r;

  // scan state
  logic [ADDR_W-1:0] seen_r, seen_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt, fill_inc;
  logic              rep_r, rep_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;

  logic                                      in_accept;
  logic                                      shift_en;
  logic [LEN_W-1:0]                          len_eff;
  logic [STORED_POSITIONS-1:0][BYTE_W-1:0]   pat_bytes;
  cell_cfg_t [NUM_CELLS-1:0]                 cell_cfg;
  logic [NUM_CELLS-1:0][BYTE_W-1:0]          cell_dout;
  logic [NUM_CELLS-1:0]                      cell_hit;
  logic                                      match;
  logic [ADDR_W-1:0]                         match_addr;

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign shift_en  = in_accept && !rep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r   <= '0;
      pat_high_r  <= '0;
      wild_mask_r <= '0;
      length_r    <= LEN_W'(1);
      base_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PAT_LOW:  pat_low_r   <= cfg_wdata;
        REG_PAT_HIGH: pat_high_r  <= cfg_wdata;
        REG_WILDCARD: wild_mask_r <= cfg_wdata[MASK_W-1:0];
        REG_LENGTH:   length_r    <= cfg_wdata[LEN_W-1:0];
        REG_BASE:     base_r      <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  always_comb begin
    if (length_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (length_r > LEN_CAP) begin
      len_eff = LEN_CAP;
    end else begin
      len_eff = length_r;
    end
  end

  assign pat_bytes = {pat_high_r, pat_low_r};

  // cell k holds the byte k steps older than the newest one
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    localparam logic [LEN_W-1:0] K = LEN_W'(k);
    logic [LEN_W-1:0]  pos;
    logic [BYTE_W-1:0] din;

    assign pos                  = len_eff - K - LEN_W'(1);
    assign cell_cfg[k].used     = (K < len_eff);
    assign cell_cfg[k].wild     = wild_mask_r[pos[POS_W-1:0]];
    assign cell_cfg[k].pat_byte = pat_bytes[pos[POS_W-1:0]];

    if (k == 0) begin : g_head
      assign din = in_tdata;
    end else begin : g_link
      assign din = cell_dout[k-1];
    end

    wbps_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .din      (din),
      .cfg      (cell_cfg[k]),
      .dout     (cell_dout[k]),
      .hit      (cell_hit[k])
    );
  end

  assign fill_inc   = (fill_r == FILL_MAX) ? fill_r : fill_r + FILL_W'(1);
  assign match      = (&cell_hit) && (LEN_W'(fill_inc) >= len_eff);
  // start offset is bytes seen after this one minus the length
  assign match_addr = base_r + seen_r - ADDR_W'(len_eff - LEN_W'(1));

  always_comb begin
    seen_nxt      = seen_r;
    fill_nxt      = fill_r;
    rep_nxt       = rep_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_found_nxt = out_found_r;
    out_addr_nxt  = out_addr_r;
    if (in_accept) begin
      if (rep_r) begin
        if (in_tlast) begin
          seen_nxt = '0;
          fill_nxt = '0;
          rep_nxt  = 1'b0;
        end
      end else begin
        seen_nxt = seen_r + ADDR_W'(1);
        fill_nxt = fill_inc;
        if (match || in_tlast) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = match;
          out_addr_nxt  = match ? match_addr : '0;
        end
        if (in_tlast) begin
          seen_nxt = '0;
          fill_nxt = '0;
          rep_nxt  = 1'b0;
        end else if (match) begin
          rep_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      fill_r      <= '0;
      rep_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      seen_r      <= seen_nxt;
      fill_r      <= fill_nxt;
      rep_r       <= rep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
    out_addr_r  <= out_addr_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_addr_r;
  assign out_tuser[0] = out_found_r;

`ifndef ASSERT_OFF
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("not-found item carries a nonzero address");

  a_region_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_tlast |=> !rep_r && seen_r == '0 && fill_r == '0)
    else $error("scan state not cleared at region end");

  a_report_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && rep_r && !in_tlast |=> rep_r && $stable(seen_r))
    else $error("bytes after a report changed the scan state");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_MAX)
    else $error("window fill above the cell count");
`endif

endmodule
